/* src/lpl_pkg.sv */
// ============================================================================
// lpl_pkg
// Shared constants of the look-ahead peak limiter.
// ============================================================================
package lpl_pkg;

    localparam int MAX_LOOKAHEAD  = 256;
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int COEFF_BITS     = 16;

    localparam int PTR_BITS  = $clog2(MAX_LOOKAHEAD);
    localparam int POS_BITS  = PTR_BITS + 1;
    localparam int GAIN_BITS = GAIN_FRAC_BITS + 1;
    localparam int CEIL_BITS = SAMPLE_BITS - 1;
    localparam int QENT_BITS = GAIN_BITS + POS_BITS;

    localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;

    // Configuration register indexes.
    localparam logic [1:0] REG_CEILING = 2'd0;
    localparam logic [1:0] REG_WINDOW  = 2'd1;
    localparam logic [1:0] REG_ATTACK  = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

endpackage

/* src/lookahead_peak_limiter.sv */
// ============================================================================
// lookahead_peak_limiter
// Look-ahead brick-wall peak limiter: serial gain divide, min-queue in RAM,
// one-pole gain smoothing and delayed, clamped output.
// ============================================================================
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+---------------------------------------
//  input    | in_valid / in_stall      | in_sample
//  output   | out_valid / out_stall    | out_sample, gain_applied, limiting,
//           |                          | engaged_count
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One sample at a time. A sample takes longer when it needs a gain divide and
// for each queue entry popped from the back or dropped from the front; the
// serial divider and the queue RAM, read one entry at a time, set its length.
// Reset clears control state; the delay line reads as zero through per-entry
// valid bits until written. A finished result waits in the output register;
// the next sample may be taken while it waits, but its own result is held
// back until that register is free. Configuration is taken only while idle.
// ============================================================================
module lookahead_peak_limiter
    import lpl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic [GAIN_BITS-1:0]          gain_applied,
    output logic                          limiting,
    output logic [31:0]                   engaged_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [CEIL_BITS-1:0]          cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DIV, S_POP_RD, S_POP_CMP, S_PUSH, S_HEAD_RD,
        S_HEAD_CMP, S_SMOOTH, S_STEP, S_MUL, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [CEIL_BITS-1:0]  ceiling_reg;
    logic [7:0]            window_reg;
    logic [COEFF_BITS-1:0] attack_reg;
    logic [COEFF_BITS-1:0] release_reg;

    // Persistent limiter state.
    logic [PTR_BITS-1:0]      dptr_reg;
    logic [MAX_LOOKAHEAD-1:0] dvalid_reg;
    logic [PTR_BITS-1:0]      head_reg;
    logic [POS_BITS-1:0]      count_reg;
    logic [POS_BITS-1:0]      spos_reg;
    logic [GAIN_BITS-1:0]     smooth_reg;
    logic [31:0]              total_reg;

    // Per-sample working registers.
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [SAMPLE_BITS-1:0]        mag_reg;
    logic signed [SAMPLE_BITS-1:0] delayed_reg;
    logic [SAMPLE_BITS:0]          rem_reg;
    logic [GAIN_FRAC_BITS-1:0]     quo_reg;
    logic [4:0]                    div_cnt_reg;
    logic [GAIN_BITS-1:0]          req_reg;
    logic [GAIN_BITS-1:0]          target_reg;
    logic                          rising_reg;
    logic [GAIN_BITS+COEFF_BITS-1:0] step_reg;
    logic signed [SAMPLE_BITS+GAIN_BITS:0] prod_reg;

    // Output registers.
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [GAIN_BITS-1:0]          gain_reg;
    logic                          limiting_reg;
    logic [31:0]                   engaged_reg;

    // RAM ports.
    logic                    d_we;
    logic [SAMPLE_BITS-1:0]  d_rdata;
    logic                    q_we;
    logic [PTR_BITS-1:0]     q_waddr;
    logic [PTR_BITS-1:0]     q_raddr;
    logic [QENT_BITS-1:0]    q_wdata;
    logic [QENT_BITS-1:0]    q_rdata;

    // Combinational helpers.
    logic [POS_BITS-1:0]        win;
    logic [SAMPLE_BITS-1:0]     in_mag;
    logic [SAMPLE_BITS:0]       rem_shift;
    logic [GAIN_BITS-1:0]       q_gain;
    logic [POS_BITS-1:0]        q_pos;
    logic [POS_BITS-1:0]        age;
    logic                       q_full;
    logic [PTR_BITS-1:0]        head_adj;
    logic [POS_BITS-1:0]        count_adj;
    logic [POS_BITS-1:0]        dptr_inc;
    logic [GAIN_BITS-1:0]       diff_mag;
    logic [GAIN_BITS-1:0]       step_val;
    logic [GAIN_BITS-1:0]       smooth_new;
    logic signed [SAMPLE_BITS+1:0] y_shift;
    logic signed [SAMPLE_BITS+1:0] ceil_s;
    logic signed [SAMPLE_BITS-1:0] y_clamp;
    logic                       out_free;

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_sample    = out_sample_reg;
    assign gain_applied  = gain_reg;
    assign limiting      = limiting_reg;
    assign engaged_count = engaged_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    // Effective window, zero acting as one.
    assign win = (window_reg == 8'd0) ? POS_BITS'(1) : POS_BITS'(window_reg);

    assign in_mag    = in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~in_sample + 1'b1)
                                                : SAMPLE_BITS'(in_sample);
    assign rem_shift = {rem_reg[SAMPLE_BITS-1:0], 1'b0};

    // Queue entry fields and window age.
    assign q_gain = q_rdata[QENT_BITS-1:POS_BITS];
    assign q_pos  = q_rdata[POS_BITS-1:0];
    assign age    = spos_reg - q_pos;

    // Queue full handling drops the oldest entry before the push.
    assign q_full    = (count_reg >= POS_BITS'(MAX_LOOKAHEAD));
    assign head_adj  = q_full ? head_reg + 1'b1 : head_reg;
    assign count_adj = q_full ? count_reg - 1'b1 : count_reg;

    assign q_raddr = (state_reg == S_HEAD_RD) ? head_reg
                                              : head_reg + PTR_BITS'(count_reg - 1'b1);
    assign q_waddr = head_adj + count_adj[PTR_BITS-1:0];
    assign q_wdata = {req_reg, spos_reg};
    assign q_we    = (state_reg == S_PUSH);
    assign d_we    = (state_reg == S_LOAD);

    assign dptr_inc = POS_BITS'(dptr_reg) + 1'b1;

    // Smoothing step toward the target.
    assign diff_mag   = (smooth_reg >= target_reg) ? smooth_reg - target_reg
                                                   : target_reg - smooth_reg;
    assign step_val   = step_reg[GAIN_BITS+COEFF_BITS-1:COEFF_BITS];
    assign smooth_new = rising_reg ? target_reg - step_val : target_reg + step_val;

    // Floor shift and clamp of the scaled sample.
    assign y_shift = $signed(prod_reg[SAMPLE_BITS+GAIN_BITS:GAIN_FRAC_BITS]);
    assign ceil_s  = (SAMPLE_BITS+2)'({1'b0, ceiling_reg});
    always_comb
    begin
        if (y_shift > ceil_s)
        begin
            y_clamp = SAMPLE_BITS'(ceil_s);
        end
        else if (y_shift < -ceil_s)
        begin
            y_clamp = SAMPLE_BITS'(-ceil_s);
        end
        else
        begin
            y_clamp = SAMPLE_BITS'(y_shift);
        end
    end

    lpl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LOOKAHEAD)) u_delay_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (dptr_reg),
        .wdata (x_reg),
        .raddr (dptr_reg),
        .rdata (d_rdata)
    );

    lpl_ram #(.WIDTH(QENT_BITS), .DEPTH(MAX_LOOKAHEAD)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg <= CEIL_BITS'(8388607);
            window_reg  <= 8'd48;
            attack_reg  <= COEFF_BITS'(60000);
            release_reg <= COEFF_BITS'(65500);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CEILING: ceiling_reg <= cfg_data;
                REG_WINDOW:  window_reg  <= cfg_data[7:0];
                REG_ATTACK:  attack_reg  <= cfg_data[COEFF_BITS-1:0];
                REG_RELEASE: release_reg <= cfg_data[COEFF_BITS-1:0];
                default:     ceiling_reg <= ceiling_reg;
            endcase
        end
    end

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg   <= in_sample;
                mag_reg <= in_mag;
            end
            S_LOAD:
            begin
                delayed_reg <= dvalid_reg[dptr_reg] ? d_rdata : '0;
                rem_reg     <= (SAMPLE_BITS+1)'(ceiling_reg);
                req_reg     <= UNITY;
            end
            S_DIV:
            begin
                if (rem_shift >= (SAMPLE_BITS+1)'(mag_reg))
                begin
                    rem_reg <= rem_shift - (SAMPLE_BITS+1)'(mag_reg);
                    quo_reg <= {quo_reg[GAIN_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[GAIN_FRAC_BITS-2:0], 1'b0};
                end
            end
            S_POP_RD:
            begin
                if (div_cnt_reg == 5'(GAIN_FRAC_BITS))
                begin
                    req_reg <= GAIN_BITS'(quo_reg);
                end
            end
            S_HEAD_CMP:
            begin
                target_reg <= q_gain;
            end
            S_SMOOTH:
            begin
                rising_reg <= (smooth_reg < target_reg);
                step_reg   <= diff_mag * ((target_reg < smooth_reg) ? attack_reg
                                                                    : release_reg);
            end
            S_MUL:
            begin
                prod_reg <= delayed_reg * $signed({1'b0, smooth_reg});
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    // Sequencer and limiter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dptr_reg      <= '0;
            dvalid_reg    <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            spos_reg      <= '0;
            smooth_reg    <= UNITY;
            total_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_sample_reg <= '0;
            gain_reg      <= '0;
            limiting_reg  <= 1'b0;
            engaged_reg   <= '0;
        end
        else
        begin
            // A finished result leaves unless a new one replaces it this cycle.
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // Delay line read is back; store the new sample.
                    dvalid_reg[dptr_reg] <= 1'b1;
                    dptr_reg    <= (dptr_inc >= win) ? '0 : dptr_inc[PTR_BITS-1:0];
                    div_cnt_reg <= '0;
                    state_reg   <= (mag_reg <= SAMPLE_BITS'(ceiling_reg)) ? S_POP_RD
                                                                           : S_DIV;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 5'(GAIN_FRAC_BITS - 1))
                    begin
                        state_reg <= S_POP_RD;
                    end
                end
                S_POP_RD:
                begin
                    div_cnt_reg <= '0;
                    state_reg <= (count_reg == '0) ? S_PUSH : S_POP_CMP;
                end
                S_POP_CMP:
                begin
                    // Pop back entries not smaller than the new requirement.
                    if (q_gain >= req_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_POP_RD;
                    end
                    else
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    head_reg  <= head_adj;
                    count_reg <= count_adj + 1'b1;
                    state_reg <= S_HEAD_RD;
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD_CMP;
                end
                S_HEAD_CMP:
                begin
                    // Drop front entries that have left the window.
                    if (count_reg != '0 && age >= win)
                    begin
                        head_reg  <= head_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_HEAD_RD;
                    end
                    else
                    begin
                        state_reg <= S_SMOOTH;
                    end
                end
                S_SMOOTH:
                begin
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    smooth_reg <= smooth_new;
                    spos_reg   <= spos_reg + 1'b1;
                    if (target_reg < UNITY && total_reg != 32'hFFFF_FFFF)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= y_clamp;
                        gain_reg       <= smooth_reg;
                        limiting_reg   <= (target_reg < UNITY);
                        engaged_reg    <= total_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/lpl_ram.sv */
// ============================================================================
// lpl_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module lpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
